>>> hdl/rational_add_reduce_defines.svh
// Assertion macros used by the checker file rar_checker.sv of rational_add_reduce.
// Each macro expects signals named i_clk and i_rst_n where it is used.
`ifndef RATIONAL_ADD_REDUCE_DEFINES_SVH
`define RATIONAL_ADD_REDUCE_DEFINES_SVH

// Property checked at every rising edge, disabled while reset is active.
`define RAR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed in %m");

// Same check with a message of its own.
`define RAR_ASSERT_MSG(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

`endif

>>> hdl/rar_pkg.sv
// Package for rational_add_reduce: widths, status codes, sequencer states,
// divider request/response types and the sign/magnitude encode function.
`timescale 1ns / 1ps

package rar_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int FIELD_W     = 32;
    localparam int MAG_W       = VALUE_WIDTH;
    localparam int DW          = 2 * VALUE_WIDTH;
    localparam int DIV_CW      = $clog2(DW);
    localparam int IN_W        = 4 * FIELD_W;
    localparam int OUT_W       = ((2 * FIELD_W + 3 + 7) / 8) * 8;

    localparam logic [DW-1:0] MAG_LIM = DW'(1) << (VALUE_WIDTH - 1);

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GCD,
        S_GCD_WAIT,
        S_CHK,
        S_DIVN_WAIT,
        S_DIVD_START,
        S_DIVD_WAIT,
        S_RED_END,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_SUM,
        S_FINAL
    } t_state;

    typedef enum logic [1:0] {
        PH_A,
        PH_B,
        PH_S
    } t_phase;

    typedef struct packed {
        logic          start;
        logic [DW-1:0] dividend;
        logic [DW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic          done;
        logic [DW-1:0] quo;
        logic [DW-1:0] rem;
    } t_div_rsp;

    function automatic logic [VALUE_WIDTH-1:0] encode(input logic neg,
                                                      input logic [VALUE_WIDTH-1:0] mag);
        encode = neg ? (VALUE_WIDTH'(0) - mag) : mag;
    endfunction

endpackage

>>> hdl/rar_div.sv
// Restoring divider, one quotient bit per cycle, shared by gcd and reduction.
// Depends on rar_pkg for widths and request/response types.
`timescale 1ns / 1ps

module rar_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rar_pkg::t_div_req i_req,
    output rar_pkg::t_div_rsp o_rsp
);

    logic                        r_busy, n_busy;
    logic                        r_done, n_done;
    logic [rar_pkg::DIV_CW-1:0]  r_cnt, n_cnt;
    logic [rar_pkg::DW-1:0]      r_div, n_div;
    logic [rar_pkg::DW:0]        r_rem, n_rem;
    logic [rar_pkg::DW-1:0]      r_quo, n_quo;
    logic [rar_pkg::DW:0]        shifted;
    logic [rar_pkg::DW:0]        diff;

    always_comb begin
        shifted = {r_rem[rar_pkg::DW-1:0], r_quo[rar_pkg::DW-1]};
        diff    = shifted - {1'b0, r_div};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_div   = r_div;
        n_rem   = r_rem;
        n_quo   = r_quo;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = rar_pkg::DIV_CW'(rar_pkg::DW - 1);
            n_div  = i_req.divisor;
            n_rem  = '0;
            n_quo  = i_req.dividend;
        end else if (r_busy) begin
            // A clear borrow bit means the shifted remainder covers the divisor.
            n_rem = diff[rar_pkg::DW] ? shifted : diff;
            n_quo = {r_quo[rar_pkg::DW-2:0], ~diff[rar_pkg::DW]};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_div <= n_div;
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem[rar_pkg::DW-1:0];

endmodule

>>> hdl/rational_add_reduce.sv
// rational_add_reduce: adds two fractions and reduces operands and sum by gcd.
// Uses rar_pkg and the shared divider rar_div.
//
// Usage:
//   The input word on s_axis carries num_a, den_a, num_b, den_b. The result
//   word on m_axis carries sum_num, sum_den, equal and status (0 ok, 1 zero
//   denominator, 2 result overflow). One word in gives exactly one word out.
// Timing:
//   The block takes one input word at a time; s_axis_tready is high only
//   while the sequencer is idle. Each word with nonzero denominators runs
//   three reductions (a, b and the sum), each a Euclid gcd and, when the gcd
//   exceeds one, two divisions, all on one 64-bit restoring divider; three
//   products and the sum are formed between the b and sum reductions. A
//   zero denominator word skips all of this and goes to the final state.
// Stall and reset:
//   The result sits in an output register until taken; the next input word
//   is accepted meanwhile, and the sequencer waits at the end only if the
//   previous result is still held. Reset empties the output register and
//   returns the sequencer to idle; there is no stored state beyond that.
`timescale 1ns / 1ps

module rational_add_reduce (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // num_a[31:0], den_a[63:32], num_b[95:64], den_b[127:96]
    input  logic [rar_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // sum_num[31:0], sum_den[63:32], equal[64], status[66:65], zero pad
    output logic [rar_pkg::OUT_W-1:0] m_axis_tdata
);

    localparam int VW = rar_pkg::VALUE_WIDTH;
    localparam int DW = rar_pkg::DW;
    localparam int MW = rar_pkg::MAG_W;

    rar_pkg::t_state r_state, n_state;
    rar_pkg::t_phase r_phase, n_phase;
    logic            r_ov, n_ov;

    // operand a and b in sign/magnitude form
    logic          r_an_neg, n_an_neg, r_ad_neg, n_ad_neg;
    logic          r_bn_neg, n_bn_neg, r_bd_neg, n_bd_neg;
    logic [MW-1:0] r_an, n_an, r_ad, n_ad, r_bn, n_bn, r_bd, n_bd;
    // working fraction under reduction and gcd pair
    logic          r_wn_neg, n_wn_neg, r_wd_neg, n_wd_neg;
    logic [DW-1:0] r_wn, n_wn, r_wd, n_wd, r_gx, n_gx, r_gy, n_gy;
    logic [DW-1:0] r_p1, n_p1, r_p2, n_p2, r_pd, n_pd;
    logic          r_equal, n_equal;
    logic          r_err, n_err;
    logic [rar_pkg::OUT_W-1:0] r_odata, n_odata;

    logic [VW-1:0] f_na, f_da, f_nb, f_db;
    logic [MW-1:0] m_na, m_da, m_nb, m_db;
    logic [MW-1:0] mul_x, mul_y;
    logic [DW-1:0] product;
    logic          p1_neg, p2_neg;
    logic          fit_n, fit_d;
    logic [VW-1:0] enc_n, enc_d;

    rar_pkg::t_div_req div_req;
    rar_pkg::t_div_rsp div_rsp;

    rar_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign f_na = s_axis_tdata[VW-1:0];
    assign f_da = s_axis_tdata[rar_pkg::FIELD_W +: VW];
    assign f_nb = s_axis_tdata[2*rar_pkg::FIELD_W +: VW];
    assign f_db = s_axis_tdata[3*rar_pkg::FIELD_W +: VW];
    assign m_na = f_na[VW-1] ? (MW'(0) - f_na) : f_na;
    assign m_da = f_da[VW-1] ? (MW'(0) - f_da) : f_da;
    assign m_nb = f_nb[VW-1] ? (MW'(0) - f_nb) : f_nb;
    assign m_db = f_db[VW-1] ? (MW'(0) - f_db) : f_db;

    assign p1_neg = r_an_neg ^ r_bd_neg;
    assign p2_neg = r_bn_neg ^ r_ad_neg;

    // one multiplier, its operands chosen by the step
    always_comb begin
        case (r_state)
            rar_pkg::S_MUL1: begin mul_x = r_an; mul_y = r_bd; end
            rar_pkg::S_MUL2: begin mul_x = r_bn; mul_y = r_ad; end
            default:         begin mul_x = r_ad; mul_y = r_bd; end
        endcase
        product = DW'(mul_x) * DW'(mul_y);
    end

    assign fit_n = r_wn_neg ? (r_wn <= rar_pkg::MAG_LIM) : (r_wn < rar_pkg::MAG_LIM);
    assign fit_d = r_wd_neg ? (r_wd <= rar_pkg::MAG_LIM) : (r_wd < rar_pkg::MAG_LIM);
    assign enc_n = rar_pkg::encode(r_wn_neg, r_wn[VW-1:0]);
    assign enc_d = rar_pkg::encode(r_wd_neg, r_wd[VW-1:0]);

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_ov     = r_ov;
        n_an_neg = r_an_neg; n_ad_neg = r_ad_neg; n_bn_neg = r_bn_neg; n_bd_neg = r_bd_neg;
        n_an     = r_an;     n_ad     = r_ad;     n_bn     = r_bn;     n_bd     = r_bd;
        n_wn_neg = r_wn_neg; n_wd_neg = r_wd_neg;
        n_wn     = r_wn;     n_wd     = r_wd;     n_gx     = r_gx;     n_gy     = r_gy;
        n_p1     = r_p1;     n_p2     = r_p2;     n_pd     = r_pd;
        n_equal  = r_equal;
        n_err    = r_err;
        n_odata  = r_odata;
        div_req  = '{start: 1'b0, dividend: r_gx, divisor: r_gy};
        s_axis_tready = 1'b0;

        if (r_ov && m_axis_tready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            rar_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_an_neg = f_na[VW-1]; n_an = m_na;
                    n_ad_neg = f_da[VW-1]; n_ad = m_da;
                    n_bn_neg = f_nb[VW-1]; n_bn = m_nb;
                    n_bd_neg = f_db[VW-1]; n_bd = m_db;
                    n_wn_neg = f_na[VW-1]; n_wn = DW'(m_na);
                    n_wd_neg = f_da[VW-1]; n_wd = DW'(m_da);
                    n_gx     = DW'(m_na);
                    n_gy     = DW'(m_da);
                    n_phase  = rar_pkg::PH_A;
                    n_err    = (m_da == '0) || (m_db == '0);
                    n_state  = n_err ? rar_pkg::S_FINAL : rar_pkg::S_GCD;
                end
            end
            rar_pkg::S_GCD: begin
                if (r_gy == '0) begin
                    n_state = rar_pkg::S_CHK;
                end else begin
                    div_req.start = 1'b1;
                    n_state = rar_pkg::S_GCD_WAIT;
                end
            end
            rar_pkg::S_GCD_WAIT: begin
                if (div_rsp.done) begin
                    n_gx    = r_gy;
                    n_gy    = div_rsp.rem;
                    n_state = rar_pkg::S_GCD;
                end
            end
            rar_pkg::S_CHK: begin
                // A gcd of one leaves the fraction as it is.
                if (r_gx > DW'(1)) begin
                    div_req = '{start: 1'b1, dividend: r_wn, divisor: r_gx};
                    n_state = rar_pkg::S_DIVN_WAIT;
                end else begin
                    n_state = rar_pkg::S_RED_END;
                end
            end
            rar_pkg::S_DIVN_WAIT: begin
                if (div_rsp.done) begin
                    n_wn    = div_rsp.quo;
                    n_state = rar_pkg::S_DIVD_START;
                end
            end
            rar_pkg::S_DIVD_START: begin
                div_req = '{start: 1'b1, dividend: r_wd, divisor: r_gx};
                n_state = rar_pkg::S_DIVD_WAIT;
            end
            rar_pkg::S_DIVD_WAIT: begin
                if (div_rsp.done) begin
                    n_wd    = div_rsp.quo;
                    n_state = rar_pkg::S_RED_END;
                end
            end
            rar_pkg::S_RED_END: begin
                n_wn_neg = r_wn_neg && (r_wn != '0);
                case (r_phase)
                    rar_pkg::PH_A: begin
                        n_an_neg = n_wn_neg;   n_an = r_wn[MW-1:0];
                        n_ad     = r_wd[MW-1:0];
                        n_wn_neg = r_bn_neg;   n_wn = DW'(r_bn);
                        n_wd_neg = r_bd_neg;   n_wd = DW'(r_bd);
                        n_gx     = DW'(r_bn);
                        n_gy     = DW'(r_bd);
                        n_phase  = rar_pkg::PH_B;
                        n_state  = rar_pkg::S_GCD;
                    end
                    rar_pkg::PH_B: begin
                        n_bn_neg = n_wn_neg;   n_bn = r_wn[MW-1:0];
                        n_bd     = r_wd[MW-1:0];
                        n_state  = rar_pkg::S_MUL1;
                    end
                    default: begin
                        n_state = rar_pkg::S_FINAL;
                    end
                endcase
            end
            rar_pkg::S_MUL1: begin
                n_p1    = product;
                n_equal = (rar_pkg::encode(r_an_neg, r_an) == rar_pkg::encode(r_bn_neg, r_bn))
                       && (rar_pkg::encode(r_ad_neg, r_ad) == rar_pkg::encode(r_bd_neg, r_bd));
                n_state = rar_pkg::S_MUL2;
            end
            rar_pkg::S_MUL2: begin
                n_p2    = product;
                n_state = rar_pkg::S_MUL3;
            end
            rar_pkg::S_MUL3: begin
                n_pd    = product;
                n_state = rar_pkg::S_SUM;
            end
            rar_pkg::S_SUM: begin
                if (p1_neg == p2_neg) begin
                    n_wn_neg = p1_neg;
                    n_wn     = r_p1 + r_p2;
                end else if (r_p1 >= r_p2) begin
                    n_wn_neg = p1_neg;
                    n_wn     = r_p1 - r_p2;
                end else begin
                    n_wn_neg = p2_neg;
                    n_wn     = r_p2 - r_p1;
                end
                n_wd_neg = r_ad_neg ^ r_bd_neg;
                n_wd     = r_pd;
                n_gx     = n_wn;
                n_gy     = r_pd;
                n_phase  = rar_pkg::PH_S;
                n_state  = rar_pkg::S_GCD;
            end
            rar_pkg::S_FINAL: begin
                if (!r_ov || m_axis_tready) begin
                    n_odata = '0;
                    if (r_err) begin
                        n_odata[2*rar_pkg::FIELD_W+1 +: 2] = rar_pkg::ST_ZERO_DEN;
                    end else if (!fit_n || !fit_d) begin
                        n_odata[2*rar_pkg::FIELD_W]        = r_equal;
                        n_odata[2*rar_pkg::FIELD_W+1 +: 2] = rar_pkg::ST_OVERFLOW;
                    end else begin
                        n_odata[0 +: rar_pkg::FIELD_W]     = rar_pkg::FIELD_W'(enc_n);
                        n_odata[rar_pkg::FIELD_W +: rar_pkg::FIELD_W] =
                            rar_pkg::FIELD_W'(enc_d);
                        n_odata[2*rar_pkg::FIELD_W]        = r_equal;
                        n_odata[2*rar_pkg::FIELD_W+1 +: 2] = rar_pkg::ST_OK;
                    end
                    n_ov    = 1'b1;
                    n_state = rar_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rar_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rar_pkg::S_IDLE;
            r_phase <= rar_pkg::PH_A;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_an_neg <= n_an_neg; r_ad_neg <= n_ad_neg; r_bn_neg <= n_bn_neg; r_bd_neg <= n_bd_neg;
        r_an     <= n_an;     r_ad     <= n_ad;     r_bn     <= n_bn;     r_bd     <= n_bd;
        r_wn_neg <= n_wn_neg; r_wd_neg <= n_wd_neg;
        r_wn     <= n_wn;     r_wd     <= n_wd;     r_gx     <= n_gx;     r_gy     <= n_gy;
        r_p1     <= n_p1;     r_p2     <= n_p2;     r_pd     <= n_pd;
        r_equal  <= n_equal;
        r_err    <= n_err;
        r_odata  <= n_odata;
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_odata;

endmodule

>>> hdl/rar_checker.sv
// Port-level checker for rational_add_reduce, attached by the bind below.
// Depends on rar_pkg and the macros in rational_add_reduce_defines.svh.
`timescale 1ns / 1ps
`include "rational_add_reduce_defines.svh"

module rar_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      s_axis_tvalid,
    input logic                      s_axis_tready,
    input logic [rar_pkg::IN_W-1:0]  s_axis_tdata,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [rar_pkg::OUT_W-1:0] m_axis_tdata
);

    logic [1:0] status;
    logic [31:0] dens_a, dens_b;
    assign status = m_axis_tdata[2*rar_pkg::FIELD_W+1 +: 2];
    assign dens_a = s_axis_tdata[63:32];
    assign dens_b = s_axis_tdata[127:96];

    `RAR_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    `RAR_ASSERT_MSG(a_busy_after_accept, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken while busy")
    `RAR_ASSERT(a_status_code, m_axis_tvalid |-> status != 2'd3)
    `RAR_ASSERT(a_error_zeroes, m_axis_tvalid && status != rar_pkg::ST_OK |-> m_axis_tdata[63:0] == 64'd0)
    `RAR_ASSERT(a_zero_den_fast, s_axis_tvalid && s_axis_tready && (dens_a == 32'd0 || dens_b == 32'd0) && !m_axis_tvalid |=> ##1 m_axis_tvalid && status == rar_pkg::ST_ZERO_DEN)

endmodule

bind rational_add_reduce rar_checker u_rar_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> test/rational_add_reduce_checker.sv
// Checker for rational_add_reduce: watches both stream channels, predicts each
// result word from the input word and compares. Depends on rar_pkg.
`timescale 1ns / 1ps

module rational_add_reduce_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic [rar_pkg::IN_W-1:0]  i_in_data,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic [rar_pkg::OUT_W-1:0] i_out_data,
    output int                        o_fail_count,
    output int                        o_pending
);

    typedef struct packed {
        logic [1:0]  status;
        logic        equal;
        logic [31:0] den;
        logic [31:0] num;
    } t_sum_word;

    t_sum_word sums_due[$];

    function automatic logic [63:0] gcd_of(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic void split_field(input logic [31:0] raw, output logic neg,
                                        output logic [63:0] mag);
        neg = raw[31];
        mag = neg ? (64'h1_0000_0000 - {32'd0, raw}) : {32'd0, raw};
    endfunction

    function automatic void reduce_pair(inout logic nn, inout logic [63:0] nm,
                                        inout logic [63:0] dm);
        logic [63:0] g;
        g = gcd_of(nm, dm);
        if (g > 1) begin
            nm = nm / g;
            dm = dm / g;
        end
        if (nm == 0) nn = 1'b0;
    endfunction

    function automatic logic [31:0] to_word(input logic neg, input logic [63:0] mag);
        logic [63:0] v;
        v = neg ? (64'd0 - mag) : mag;
        return v[31:0];
    endfunction

    function automatic logic fits_word(input logic neg, input logic [63:0] mag);
        return neg ? (mag <= 64'h8000_0000) : (mag < 64'h8000_0000);
    endfunction

    function automatic t_sum_word predict_sum(input logic [rar_pkg::IN_W-1:0] w);
        t_sum_word r;
        logic an, ad, bn, bd, p1n, p2n, sn, sd;
        logic [63:0] anm, adm, bnm, bdm, p1, p2, snm, sdm;
        r = '0;
        split_field(w[31:0], an, anm);
        split_field(w[63:32], ad, adm);
        split_field(w[95:64], bn, bnm);
        split_field(w[127:96], bd, bdm);
        if (adm == 0 || bdm == 0) begin
            r.status = rar_pkg::ST_ZERO_DEN;
            return r;
        end
        reduce_pair(an, anm, adm);
        reduce_pair(bn, bnm, bdm);
        r.equal = (to_word(an, anm) == to_word(bn, bnm)) &&
                  (to_word(ad, adm) == to_word(bd, bdm));
        p1n = an != bd;
        p1 = anm * bdm;
        p2n = bn != ad;
        p2 = bnm * adm;
        if (p1n == p2n) begin
            sn = p1n;
            snm = p1 + p2;
        end else if (p1 >= p2) begin
            sn = p1n;
            snm = p1 - p2;
        end else begin
            sn = p2n;
            snm = p2 - p1;
        end
        sd = ad != bd;
        sdm = adm * bdm;
        reduce_pair(sn, snm, sdm);
        if (!fits_word(sn, snm) || !fits_word(sd, sdm)) begin
            r.status = rar_pkg::ST_OVERFLOW;
            return r;
        end
        r.num = to_word(sn, snm);
        r.den = to_word(sd, sdm);
        r.status = rar_pkg::ST_OK;
        return r;
    endfunction

    assign o_pending = sums_due.size();

    always @(posedge i_clk) begin
        t_sum_word got, want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_in_valid && i_in_ready) sums_due.push_back(predict_sum(i_in_data));
            if (i_out_valid && i_out_ready) begin
                got = i_out_data[66:0];
                if (sums_due.size() == 0) begin
                    if (o_fail_count < 10) $display("unexpected result word %h", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = sums_due.pop_front();
                    if (got !== want) begin
                        if (o_fail_count < 10)
                            $display({"mismatch: expected num %h den %h eq %b st %0d,",
                                      " got num %h den %h eq %b st %0d"},
                                     want.num, want.den, want.equal, want.status,
                                     got.num, got.den, got.equal, got.status);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

>>> test/testbench.sv
// Top of the rational_add_reduce test: drives random and directed fraction
// pairs, stalls the result side, and reports the verdict from the checker.
`timescale 1ns / 1ps

module testbench;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [rar_pkg::IN_W-1:0]  s_axis_tdata;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [rar_pkg::OUT_W-1:0] m_axis_tdata;
    int                        fail_count;
    int                        pending;
    logic                      calm;

    rational_add_reduce dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    rational_add_reduce_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready), .i_in_data(s_axis_tdata),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #1s;
        $display("status: fail");
        $finish;
    end

    // The receiver stalls at random except during calm stretches.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 26);
        end
    end

    // Mostly small magnitudes so the gcd loops stay short; some full-width values.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0, 1: return $urandom();
            2:    return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
            3:    return 32'($signed($urandom_range(8)) - 4);
            4:    return $urandom() & 32'h8000_ffff;
            default: return 32'($signed($urandom_range(200)) - 100);
        endcase
    endfunction

    // The word stays valid after it is taken; the next call replaces or drops it.
    task automatic send_word(input logic [31:0] na, input logic [31:0] da,
                             input logic [31:0] nb, input logic [31:0] db);
        while ($urandom_range(99) < 26 && !calm) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {db, nb, da, na};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] dv;
        int wait_cycles;
        calm = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(32'd1, 32'd2, 32'd1, 32'd3);
        send_word(32'd2, 32'd4, 32'd1, 32'd2);
        send_word(-32'sd1, -32'sd2, 32'd1, 32'd2);
        send_word(32'd0, -32'sd5, 32'd3, 32'd1);
        send_word(32'd5, 32'd0, 32'd1, 32'd1);
        send_word(32'd5, 32'd1, 32'd1, 32'd0);
        send_word(32'd0, 32'd0, 32'd0, 32'd0);
        send_word(32'h7fff_ffff, 32'd1, 32'd1, 32'd1);
        send_word(32'h8000_0000, 32'd1, -32'sd1, 32'd1);
        send_word(32'h8000_0000, 32'd1, 32'd0, 32'd1);
        send_word(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        send_word(32'd1, 32'h7fff_ffff, 32'd1, 32'h7fff_fffe);
        send_word(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_word(32'd7, 32'd1, 32'd7, 32'd1);
        send_word(32'd3, -32'sd4, -32'sd3, 32'd4);
        send_word(32'h8000_0000, -32'sd1, 32'd0, 32'd1);
        send_word(32'd12, 32'd1, 32'd5, 32'd1);
        s_axis_tvalid <= 1'b0;

        // Hold the sender until the pipeline has drained once.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);

        for (int n = 0; n < 1100; n++) begin
            calm = (n >= 500 && n < 600);
            dv = pick_value();
            if ($urandom_range(49) == 0) dv = 32'd0;
            case ($urandom_range(3))
                0: send_word(pick_value(), pick_value(), pick_value(), 32'd1);
                1: send_word(pick_value(), dv, pick_value(), dv);
                default: send_word(pick_value(), dv, pick_value(),
                                   $urandom_range(29) == 0 ? 32'd0 : pick_value());
            endcase
        end
        s_axis_tvalid <= 1'b0;
        calm = 1'b0;

        @(posedge i_clk);
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 2000000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (200) @(posedge i_clk);
        if (pending == 0 && fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

>>> files.f
+incdir+hdl
hdl/rar_pkg.sv
hdl/rar_div.sv
hdl/rational_add_reduce.sv
hdl/rar_checker.sv
test/rational_add_reduce_checker.sv
test/testbench.sv
